[design/beep_pattern_sequencer_assert.svh]
// ----------------------------------------------------------------------------
// beep_pattern_sequencer_assert.svh
// Assertion macros shared by the beep pattern sequencer modules.
// ----------------------------------------------------------------------------
`ifndef BEEP_PATTERN_SEQUENCER_ASSERT_SVH
`define BEEP_PATTERN_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/bps_pkg.sv]
// ----------------------------------------------------------------------------
// bps_pkg
// Types, command codes and pattern sheet contents of the beep pattern
// sequencer.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int unsigned SHEET_COUNT = 17;
  localparam int unsigned SHEET_LEN   = 19;
  localparam int unsigned SHEET_IDX_W = 5;
  localparam logic [7:0]  STOP_MARK   = 8'hFF;

  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_PLAY       = 2'd1,
    CMD_STOP       = 2'd2,
    CMD_SET_REPEAT = 2'd3
  } bps_cmd_t;

  typedef enum logic {
    ST_LOAD = 1'b0,
    ST_RUN  = 1'b1
  } bps_state_t;

  typedef struct packed {
    logic beeper_on;
    logic playing;
  } bps_result_t;

  typedef logic [0:SHEET_LEN-1][7:0] bps_row_t;

  function automatic bps_row_t sheet_row(input logic [7:0] sheet);
    bps_row_t row;
    unique case (sheet)
      8'd0:  row = '{0: 8'd10, 1: 8'd10, default: STOP_MARK};
      8'd1:  row = '{0: 8'd10, 1: 8'd10, 2: 8'd10, 3: 8'd10, default: STOP_MARK};
      8'd2:  row = '{0: 8'd30, 1: 8'd5, 2: 8'd5, 3: 8'd5, default: STOP_MARK};
      8'd3:  row = '{0: 8'd0, 1: 8'd245, 2: 8'd10, 3: 8'd5, default: STOP_MARK};
      8'd4:  row = '{0: 8'd15, 1: 8'd5, 2: 8'd15, 3: 8'd5, default: STOP_MARK};
      8'd5:  row = '{0: 8'd0, 1: 8'd100, 2: 8'd10, default: STOP_MARK};
      8'd6:  row = '{0: 8'd25, 1: 8'd50, default: STOP_MARK};
      8'd7:  row = '{0: 8'd50, 1: 8'd2, default: STOP_MARK};
      8'd8:  row = '{0: 8'd50, 1: 8'd50, default: STOP_MARK};
      8'd9:  row = '{0: 8'd10, 1: 8'd10, 2: 8'd10, 3: 8'd10, 4: 8'd10, 5: 8'd40,
                     6: 8'd40, 7: 8'd10, 8: 8'd40, 9: 8'd10, 10: 8'd40, 11: 8'd40,
                     12: 8'd10, 13: 8'd10, 14: 8'd10, 15: 8'd10, 16: 8'd10,
                     17: 8'd70, default: STOP_MARK};
      8'd10: row = '{0: 8'd5, 1: 8'd5, 2: 8'd15, 3: 8'd5, 4: 8'd5, 5: 8'd5,
                     6: 8'd15, 7: 8'd30, default: STOP_MARK};
      8'd11: row = '{0: 8'd4, 1: 8'd5, 2: 8'd4, 3: 8'd5, 4: 8'd8, 5: 8'd5,
                     6: 8'd15, 7: 8'd5, 8: 8'd8, 9: 8'd5, 10: 8'd4, 11: 8'd5,
                     12: 8'd4, 13: 8'd5, default: STOP_MARK};
      8'd12: row = '{0: 8'd5, 1: 8'd5, 2: 8'd5, 3: 8'd5, default: STOP_MARK};
      8'd13: row = '{0: 8'd20, 1: 8'd15, 2: 8'd35, 3: 8'd5, default: STOP_MARK};
      8'd14: row = '{0: 8'd20, 1: 8'd10, 2: 8'd20, 3: 8'd10, 4: 8'd20, 5: 8'd10,
                     default: STOP_MARK};
      8'd15: row = '{0: 8'd10, 1: 8'd10, 2: 8'd10, 3: 8'd10, 4: 8'd10, 5: 8'd40,
                     6: 8'd40, 7: 8'd10, 8: 8'd80, 9: 8'd160, default: STOP_MARK};
      8'd16: row = '{0: 8'd40, 1: 8'd5, 2: 8'd5, 3: 8'd5, 4: 8'd5, 5: 8'd5,
                     default: STOP_MARK};
      default: row = '{default: STOP_MARK};
    endcase
    return row;
  endfunction

  // Anything beyond a sheet reads as the stop mark.
  function automatic logic [7:0] sheet_entry(input logic [7:0] sheet,
                                             input logic [7:0] step);
    bps_row_t row;
    row = sheet_row(sheet);
    if (step < 8'(SHEET_LEN)) begin
      return row[step[SHEET_IDX_W-1:0]];
    end
    return STOP_MARK;
  endfunction

  function automatic logic [7:0] first_step(input logic [4:0] sheet);
    return sheet_entry({3'b000, sheet}, 8'd0);
  endfunction

  function automatic logic [7:0] second_step(input logic [4:0] sheet);
    return sheet_entry({3'b000, sheet}, 8'd1);
  endfunction

endpackage

[design/beep_pattern_sequencer.sv]
// Output: each taken request's result is registered in the output buffer.
// Throughput: one request per cycle while in_stall is low; a step advance reads the
// next-but-one entry of the pattern memory and forwards it from the read register in
// the following cycle. Reset: synchronous, active low; then the pattern memory's
// PATTERN_SLOTS*STEPS_PER_PATTERN entries (1024 by default) fill with in_stall high.
// ----------------------------------------------------------------------------
// beep_pattern_sequencer
// Plays on/off beep patterns from a pattern memory on tick, play, stop and
// set-repeat requests, one result per request.
// ----------------------------------------------------------------------------
module beep_pattern_sequencer #(
  parameter int unsigned PATTERN_SLOTS     = 32,
  parameter int unsigned STEPS_PER_PATTERN = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  input  logic [4:0] in_pattern_select,
  input  logic       in_repeat_enable,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_beeper_on,
  output logic       out_playing
);

  import bps_pkg::*;

  localparam int unsigned DEPTH  = PATTERN_SLOTS * STEPS_PER_PATTERN;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic              busy;
  logic              buf_full;
  logic              in_accept;
  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;
  bps_result_t       result;
  bps_result_t       out_data;

  assign in_stall  = busy || buf_full;
  assign in_accept = in_valid && !in_stall;

  bps_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_pattern_mem (
    .clk     (clk),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bps_ctrl #(
    .PATTERN_SLOTS     (PATTERN_SLOTS),
    .STEPS_PER_PATTERN (STEPS_PER_PATTERN)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept_i         (in_accept),
    .command_i        (in_command),
    .pattern_select_i (in_pattern_select),
    .repeat_enable_i  (in_repeat_enable),
    .ram_rdata_i      (ram_rdata),
    .busy_o           (busy),
    .ram_we_o         (ram_we),
    .ram_waddr_o      (ram_waddr),
    .ram_wdata_o      (ram_wdata),
    .ram_re_o         (ram_re),
    .ram_raddr_o      (ram_raddr),
    .result_o         (result)
  );

  bps_obuf u_obuf (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (in_accept),
    .push_data_i (result),
    .out_stall_i (out_stall),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .full_o      (buf_full)
  );

  assign out_beeper_on = out_data.beeper_on;
  assign out_playing   = out_data.playing;

endmodule

[design/bps_ram.sv]
// ----------------------------------------------------------------------------
// bps_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module bps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem_r[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_r <= mem_r[raddr_i];
    end
  end

  assign rdata_o = rdata_r;

endmodule

[design/bps_ctrl.sv]
// ----------------------------------------------------------------------------
// bps_ctrl
// Pattern memory fill after reset and the beep sequencer proper. The period
// of the current step and the one after it are held locally; a step advance
// fetches the entry two ahead from the pattern memory and forwards it from
// the read register in the following cycle.
// ----------------------------------------------------------------------------
`include "beep_pattern_sequencer_assert.svh"

module bps_ctrl #(
  parameter int unsigned PATTERN_SLOTS     = 32,
  parameter int unsigned STEPS_PER_PATTERN = 32
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              accept_i,
  input  logic [1:0]                                        command_i,
  input  logic [4:0]                                        pattern_select_i,
  input  logic                                              repeat_enable_i,
  input  logic [7:0]                                        ram_rdata_i,
  output logic                                              busy_o,
  output logic                                              ram_we_o,
  output logic [$clog2(PATTERN_SLOTS*STEPS_PER_PATTERN)-1:0] ram_waddr_o,
  output logic [7:0]                                        ram_wdata_o,
  output logic                                              ram_re_o,
  output logic [$clog2(PATTERN_SLOTS*STEPS_PER_PATTERN)-1:0] ram_raddr_o,
  output bps_pkg::bps_result_t                              result_o
);

  import bps_pkg::*;

  localparam int unsigned DEPTH  = PATTERN_SLOTS * STEPS_PER_PATTERN;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned SLOT_W = $clog2(PATTERN_SLOTS);
  localparam int unsigned STEP_W = $clog2(STEPS_PER_PATTERN);

  // ---- fill sequencer ------------------------------------------------------
  bps_state_t         state_r, state_nxt;
  logic [ADDR_W-1:0]  load_idx_r, load_idx_nxt;
  logic [SLOT_W-1:0]  load_sheet_r, load_sheet_nxt;
  logic [STEP_W-1:0]  load_step_r, load_step_nxt;
  logic               load_last;

  assign load_last = (load_idx_r == ADDR_W'(DEPTH - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: if (load_last) begin
        state_nxt = ST_RUN;
      end
      ST_RUN:  state_nxt = ST_RUN;
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    busy_o   = (state_r == ST_LOAD);
    ram_we_o = (state_r == ST_LOAD);
  end

  always_comb begin
    load_idx_nxt   = load_idx_r;
    load_sheet_nxt = load_sheet_r;
    load_step_nxt  = load_step_r;
    if (busy_o && !load_last) begin
      load_idx_nxt = load_idx_r + ADDR_W'(1);
      if (load_step_r == STEP_W'(STEPS_PER_PATTERN - 1)) begin
        load_step_nxt  = '0;
        load_sheet_nxt = load_sheet_r + SLOT_W'(1);
      end else begin
        load_step_nxt = load_step_r + STEP_W'(1);
      end
    end
  end

  assign ram_waddr_o = load_idx_r;
  assign ram_wdata_o = sheet_entry(8'(load_sheet_r), 8'(load_step_r));

  // ---- beep sequencer ------------------------------------------------------
  bps_cmd_t           cmd;
  logic               pin_r, pin_nxt;
  logic               active_r, active_nxt;
  logic               repeat_r, repeat_nxt;
  logic               have_r, have_nxt;
  logic [4:0]         pat_r, pat_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [7:0]         tick_r, tick_nxt;
  logic [7:0]         period_r, period_nxt;
  logic [7:0]         ahead_val_r, ahead_val_nxt;
  logic               fwd_r, fwd_nxt;
  logic [7:0]         ahead_eff;
  logic [7:0]         tick_inc;
  logic [STEP_W-1:0]  step_inc;
  logic [STEP_W:0]    step_ahead;
  logic               ahead_ok;
  logic               sel_ok;

  assign cmd        = bps_cmd_t'(command_i);
  assign ahead_eff  = fwd_r ? ram_rdata_i : ahead_val_r;
  assign tick_inc   = tick_r + 8'd1;
  assign step_inc   = step_r + STEP_W'(1);
  assign step_ahead = {1'b0, step_r} + (STEP_W + 1)'(2);
  assign ahead_ok   = (step_ahead < (STEP_W + 1)'(STEPS_PER_PATTERN));
  assign sel_ok     = (pattern_select_i < 5'(SHEET_COUNT)) &&
                      (9'(pattern_select_i) < 9'(PATTERN_SLOTS));

  assign ram_raddr_o = ADDR_W'(ADDR_W'(pat_r) * ADDR_W'(STEPS_PER_PATTERN))
                     + ADDR_W'(step_ahead);

  always_comb begin
    pin_nxt       = pin_r;
    active_nxt    = active_r;
    repeat_nxt    = repeat_r;
    have_nxt      = have_r;
    pat_nxt       = pat_r;
    step_nxt      = step_r;
    tick_nxt      = tick_r;
    period_nxt    = period_r;
    ahead_val_nxt = ahead_eff;
    fwd_nxt       = 1'b0;
    ram_re_o      = 1'b0;
    if (accept_i) begin
      unique case (cmd)
        CMD_TICK: if (have_r && active_r) begin
          if (tick_inc > period_r) begin
            tick_nxt = '0;
            if (ahead_eff == STOP_MARK) begin
              pin_nxt = 1'b0;
              if (repeat_r) begin
                // loop back to the head of the sheet
                step_nxt      = '0;
                period_nxt    = first_step(pat_r);
                ahead_val_nxt = second_step(pat_r);
              end else begin
                active_nxt = 1'b0;
              end
            end else begin
              step_nxt   = step_inc;
              period_nxt = ahead_eff;
              pin_nxt    = ~step_inc[0];
              // fetch the entry after the new step; forward it next cycle
              if (ahead_ok) begin
                ram_re_o = 1'b1;
                fwd_nxt  = 1'b1;
              end else begin
                ahead_val_nxt = STOP_MARK;
              end
            end
          end else begin
            tick_nxt = tick_inc;
            pin_nxt  = ~step_r[0];
          end
        end
        CMD_PLAY: if (sel_ok && (!have_r || (pattern_select_i != pat_r) || !active_r)) begin
          pat_nxt       = pattern_select_i;
          have_nxt      = 1'b1;
          tick_nxt      = '0;
          step_nxt      = '0;
          active_nxt    = 1'b1;
          period_nxt    = first_step(pattern_select_i);
          ahead_val_nxt = second_step(pattern_select_i);
          pin_nxt       = (first_step(pattern_select_i) != 8'd0);
        end
        CMD_STOP: begin
          active_nxt = 1'b0;
          repeat_nxt = 1'b0;
          pin_nxt    = 1'b0;
        end
        CMD_SET_REPEAT: repeat_nxt = repeat_enable_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    result_o.beeper_on = pin_nxt;
    result_o.playing   = active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      load_idx_r   <= '0;
      load_sheet_r <= '0;
      load_step_r  <= '0;
      pin_r        <= 1'b0;
      active_r     <= 1'b0;
      repeat_r     <= 1'b0;
      have_r       <= 1'b0;
      pat_r        <= '0;
      step_r       <= '0;
      tick_r       <= '0;
      fwd_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      load_idx_r   <= load_idx_nxt;
      load_sheet_r <= load_sheet_nxt;
      load_step_r  <= load_step_nxt;
      pin_r        <= pin_nxt;
      active_r     <= active_nxt;
      repeat_r     <= repeat_nxt;
      have_r       <= have_nxt;
      pat_r        <= pat_nxt;
      step_r       <= step_nxt;
      tick_r       <= tick_nxt;
      fwd_r        <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    period_r    <= period_nxt;
    ahead_val_r <= ahead_val_nxt;
  end

  `BPS_ASSERT_NOW(a_pin_needs_active, pin_r, active_r, "beeper on while sequencer idle")
  `BPS_ASSERT_NOW(a_active_needs_sheet, active_r, have_r, "active without a chosen sheet")
  `BPS_ASSERT_NOW(a_no_request_in_fill, busy_o, !accept_i, "request taken during memory fill")

endmodule

[design/bps_obuf.sv]
// ----------------------------------------------------------------------------
// bps_obuf
// Two-entry result buffer: an output register backed by a skid register so
// that the request side sees a registered stall.
// ----------------------------------------------------------------------------
`include "beep_pattern_sequencer_assert.svh"

module bps_obuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_i,
  input  bps_pkg::bps_result_t push_data_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output bps_pkg::bps_result_t out_data_o,
  output logic                 full_o
);

  import bps_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  bps_result_t out_data_r, out_data_nxt;
  bps_result_t skid_data_r, skid_data_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || !out_stall_i;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_free) begin
      priority if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (push_i) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = push_data_i;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (push_i) begin
      // hold the new result behind the stalled one
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_data_r;
  assign full_o      = skid_valid_r;

  `BPS_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r, "skid entry without output entry")
  `BPS_ASSERT_NEXT(a_skid_drains, skid_valid_r && !out_stall_i, !skid_valid_r, "skid not drained")
  `BPS_ASSERT_NEXT(a_skid_catches, push_i && out_valid_r && out_stall_i, skid_valid_r,
                   "result lost behind stalled output")

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives the beep pattern sequencer with tick, play, stop and set-repeat
// requests. An internal model of the sheets predicts the pin level and the
// playing flag after each request, and every result is checked in order.
// ----------------------------------------------------------------------------
module testbench;
  import bps_pkg::*;

  localparam int unsigned ITEM_GOAL = 1650;

  // Tracks sequencer state and the pin/playing levels still due from the block.
  class pattern_tracker;
    bps_result_t levels_due[$];
    int unsigned failures = 0;
    int unsigned checked  = 0;

    bit               pin_on    = 1'b0;
    bit               active    = 1'b0;
    bit               looping   = 1'b0;
    bit               have_sheet = 1'b0;
    int unsigned      sheet     = 0;
    int unsigned      step      = 0;
    logic [7:0]       ticks     = 8'd0;

    // Durations of each sheet; anything beyond the list reads as the stop mark.
    function int unsigned duration(int unsigned s, int unsigned k);
      int unsigned row[$];
      case (s)
        0:  row = '{10, 10};
        1:  row = '{10, 10, 10, 10};
        2:  row = '{30, 5, 5, 5};
        3:  row = '{0, 245, 10, 5};
        4:  row = '{15, 5, 15, 5};
        5:  row = '{0, 100, 10};
        6:  row = '{25, 50};
        7:  row = '{50, 2};
        8:  row = '{50, 50};
        9:  row = '{10, 10, 10, 10, 10, 40, 40, 10, 40, 10, 40, 40, 10, 10, 10, 10, 10,
                    70};
        10: row = '{5, 5, 15, 5, 5, 5, 15, 30};
        11: row = '{4, 5, 4, 5, 8, 5, 15, 5, 8, 5, 4, 5, 4, 5};
        12: row = '{5, 5, 5, 5};
        13: row = '{20, 15, 35, 5};
        14: row = '{20, 10, 20, 10, 20, 10};
        15: row = '{10, 10, 10, 10, 10, 40, 40, 10, 80, 160};
        16: row = '{40, 5, 5, 5, 5, 5};
        default: ;
      endcase
      if (k < row.size()) return row[k];
      return STOP_MARK;
    endfunction

    // Apply one accepted request; returns 0 when the block simply ignores it.
    function bit take_request(bps_cmd_t cmd, logic [4:0] sel, logic rep);
      bit          moved;
      bit          wrapped;
      int unsigned dur;
      bps_result_t want;
      moved   = 1'b1;
      wrapped = 1'b0;
      case (cmd)
        CMD_TICK: begin
          if (!have_sheet || !active) begin
            moved = 1'b0;
          end else begin
            dur   = duration(sheet, step);
            ticks = ticks + 8'd1;
            if (int'(ticks) > dur) begin
              step++;
              ticks = 8'd0;
              if (duration(sheet, step) == STOP_MARK) begin
                wrapped = 1'b1;
                pin_on  = 1'b0;
                if (looping) step = 0;
                else active = 1'b0;
              end
            end
            if (!wrapped) pin_on = (step % 2 == 0);
          end
        end
        CMD_PLAY: begin
          if (sel >= SHEET_COUNT) begin
            moved = 1'b0;
          end else if (have_sheet && sel == sheet && active) begin
            moved = 1'b0;
          end else begin
            sheet      = sel;
            have_sheet = 1'b1;
            ticks      = 8'd0;
            step       = 0;
            active     = 1'b1;
            pin_on     = (duration(sel, 0) != 0);
          end
        end
        CMD_STOP: begin
          active  = 1'b0;
          looping = 1'b0;
          pin_on  = 1'b0;
        end
        CMD_SET_REPEAT: begin
          looping = rep;
        end
        default: ;
      endcase
      want.beeper_on = pin_on;
      want.playing   = active;
      levels_due.push_back(want);
      return moved;
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void check_levels(logic on, logic play);
      bps_result_t want;
      checked++;
      if (levels_due.size() == 0) begin
        note_failure($sformatf("result %0d with nothing due: beeper_on %b playing %b",
                               checked, on, play));
        return;
      end
      want = levels_due.pop_front();
      if (on !== want.beeper_on)
        note_failure($sformatf("result %0d beeper_on: expected %b, got %b",
                               checked, want.beeper_on, on));
      if (play !== want.playing)
        note_failure($sformatf("result %0d playing: expected %b, got %b",
                               checked, want.playing, play));
    endfunction

    function int unsigned pending();
      return levels_due.size();
    endfunction
  endclass

  logic       clk               = 1'b0;
  logic       rst_n             = 1'b0;
  logic       in_valid          = 1'b0;
  logic       in_stall;
  logic [1:0] in_command        = 2'd0;
  logic [4:0] in_pattern_select = 5'd0;
  logic       in_repeat_enable  = 1'b0;
  logic       out_valid;
  logic       out_stall         = 1'b0;
  logic       out_beeper_on;
  logic       out_playing;

  pattern_tracker tracker;
  bit             calm = 1'b0;
  int unsigned    effective_items = 0;

  beep_pattern_sequencer uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_pattern_select (in_pattern_select),
    .in_repeat_enable  (in_repeat_enable),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_beeper_on     (out_beeper_on),
    .out_playing       (out_playing)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("simulation failed");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(bps_cmd_t cmd, logic [4:0] sel, logic rep);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_command        <= cmd;
    in_pattern_select <= sel;
    in_repeat_enable  <= rep;
    do @(posedge clk); while (in_stall !== 1'b0);
    void'(tracker.take_request(cmd, sel, rep));
    effective_items++;
    @(negedge clk);
  endtask

  // Result side: random stall bursts, one long hold-off to back the block up.
  initial begin
    int unsigned burst;
    int unsigned hold;
    bit          held;
    burst = 0;
    hold  = 0;
    held  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && !out_stall)
        tracker.check_levels(out_beeper_on, out_playing);
      @(negedge clk);
      if (!held && tracker.checked >= 400) begin
        held = 1'b1;
        hold = 150;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 19) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned len;
    int unsigned k;
    logic [4:0]  pick;
    tracker = new();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: idle requests, undefined sheets, zero first step, replay, stop.
    send_request(CMD_TICK, 5'd0, 1'b0);
    send_request(CMD_STOP, 5'd0, 1'b0);
    send_request(CMD_PLAY, 5'd31, 1'b1);
    send_request(CMD_PLAY, 5'd17, 1'b0);
    send_request(CMD_TICK, 5'd31, 1'b1);
    send_request(CMD_SET_REPEAT, 5'd31, 1'b1);
    send_request(CMD_PLAY, 5'd3, 1'b0);
    send_request(CMD_TICK, 5'd0, 1'b0);
    send_request(CMD_PLAY, 5'd3, 1'b1);
    send_request(CMD_TICK, 5'd0, 1'b0);
    send_request(CMD_PLAY, 5'd5, 1'b0);
    send_request(CMD_STOP, 5'd31, 1'b1);
    send_request(CMD_TICK, 5'd0, 1'b0);
    send_request(CMD_PLAY, 5'd5, 1'b0);
    send_request(CMD_SET_REPEAT, 5'd0, 1'b0);
    send_request(CMD_PLAY, 5'd16, 1'b0);
    send_request(CMD_TICK, 5'd16, 1'b1);
    send_request(CMD_PLAY, 5'd0, 1'b0);
    repeat (4) send_request(CMD_TICK, 5'd0, 1'b0);

    while (effective_items < ITEM_GOAL) begin
      calm = (effective_items + 150 >= ITEM_GOAL);
      if ($urandom_range(0, 3) != 0) begin
        // Well-formed run: optional repeat, play, then mostly ticks.
        pick = 5'($urandom_range(0, SHEET_COUNT - 1));
        if ($urandom_range(0, 1) == 1)
          send_request(CMD_SET_REPEAT, 5'($urandom), 1'($urandom));
        send_request(CMD_PLAY, pick, 1'($urandom));
        k = $urandom_range(0, 19);
        if (k < 13) len = $urandom_range(1, 40);
        else if (k < 19) len = $urandom_range(41, 160);
        else len = $urandom_range(161, 320);
        repeat (len) begin
          k = $urandom_range(0, 59);
          if (k == 0) send_request(CMD_PLAY, pick, 1'($urandom));
          else if (k == 1) send_request(CMD_SET_REPEAT, 5'($urandom), 1'($urandom));
          else if (k == 2) send_request(CMD_STOP, 5'($urandom), 1'($urandom));
          else send_request(CMD_TICK, 5'($urandom), 1'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 4))
          send_request(bps_cmd_t'(2'($urandom)), 5'($urandom), 1'($urandom));
      end
    end
    in_valid <= 1'b0;

    n = 0;
    while (tracker.pending() != 0 && n < 5000) begin
      @(posedge clk);
      n++;
    end
    repeat (5) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[beep_pattern_sequencer.f]
+incdir+design
design/bps_pkg.sv
design/bps_ram.sv
design/bps_ctrl.sv
design/bps_obuf.sv
design/beep_pattern_sequencer.sv
tb/testbench.sv
